// ===== hdl/salu_pkg.sv =====
// shared types and constants for the sixteen-bit alu with ex word
package salu_pkg;

   localparam logic [4:0] CMD_SET = 5'd0;
   localparam logic [4:0] CMD_ADD = 5'd1;
   localparam logic [4:0] CMD_SUB = 5'd2;
   localparam logic [4:0] CMD_MUL = 5'd3;
   localparam logic [4:0] CMD_MLI = 5'd4;
   localparam logic [4:0] CMD_DIV = 5'd5;
   localparam logic [4:0] CMD_DVI = 5'd6;
   localparam logic [4:0] CMD_MOD = 5'd7;
   localparam logic [4:0] CMD_MDI = 5'd8;
   localparam logic [4:0] CMD_AND = 5'd9;
   localparam logic [4:0] CMD_BOR = 5'd10;
   localparam logic [4:0] CMD_XOR = 5'd11;
   localparam logic [4:0] CMD_SHR = 5'd12;
   localparam logic [4:0] CMD_ASR = 5'd13;
   localparam logic [4:0] CMD_SHL = 5'd14;
   localparam logic [4:0] CMD_ADX = 5'd15;
   localparam logic [4:0] CMD_SBX = 5'd16;

   localparam int DIV_STEPS = 32;
   // cell after which the remainder of the upper half is b mod a
   localparam int MID_STEP  = 16;
   localparam logic [15:0] ALL_ONES = 16'hffff;

   typedef struct packed {
      logic [4:0]  command;
      logic [15:0] operand_b;
      logic [15:0] operand_a;
      logic [15:0] ex_in;
   } req_type;

   typedef struct packed {
      logic [15:0] result;
      logic [15:0] ex_out;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  command;
      logic [15:0] res;
      logic [15:0] exo;
      logic        dz;
      logic        neg_q;
      logic        neg_r;
      logic [15:0] divisor;
      logic [15:0] rem;
      logic [31:0] dvd;
      logic [15:0] rem_mid;
   } stage_type;

endpackage

// ===== hdl/salu_prep.sv =====
// front end: simple ops, multiply, shifts and divider setup
module salu_prep (
   input  salu_pkg::req_type   req,
   output salu_pkg::stage_type stage
);

   logic signed [16:0] mul_x;
   logic signed [16:0] mul_y;
   logic signed [33:0] prod;
   logic [16:0]        sum_ab;
   logic [17:0]        sum_adx;
   logic [16:0]        sum_aex;
   logic [31:0]        shr_v;
   logic signed [47:0] asr_v;
   logic [47:0]        shl_v;
   logic [5:0]         asr_n;
   logic               big_shift;
   logic               is_signed;
   logic [15:0]        mag_b;
   logic [15:0]        mag_a;

   always_comb begin
      is_signed = (req.command == salu_pkg::CMD_MLI) || (req.command == salu_pkg::CMD_DVI)
                  || (req.command == salu_pkg::CMD_MDI);
      mul_x = $signed({is_signed & req.operand_b[15], req.operand_b});
      mul_y = $signed({is_signed & req.operand_a[15], req.operand_a});
      prod = mul_x * mul_y;
      sum_ab = {1'b0, req.operand_b} + {1'b0, req.operand_a};
      sum_adx = {2'b0, req.operand_b} + {2'b0, req.operand_a} + {2'b0, req.ex_in};
      sum_aex = {1'b0, req.operand_a} + {1'b0, req.ex_in};
      big_shift = |req.operand_a[15:5];
      shr_v = {req.operand_b, 16'h0000} >> req.operand_a[4:0];
      asr_n = big_shift ? 6'd32 : {1'b0, req.operand_a[4:0]};
      asr_v = $signed({{16{req.operand_b[15]}}, req.operand_b, 16'h0000}) >>> asr_n;
      shl_v = {32'h0, req.operand_b} << req.operand_a[4:0];
      mag_b = (is_signed && req.operand_b[15]) ? 16'(-req.operand_b) : req.operand_b;
      mag_a = (is_signed && req.operand_a[15]) ? 16'(-req.operand_a) : req.operand_a;

      stage.command = req.command;
      stage.res = req.operand_b;
      stage.exo = req.ex_in;
      stage.dz = (req.operand_a == 16'h0000);
      stage.neg_q = req.operand_b[15] ^ req.operand_a[15];
      stage.neg_r = req.operand_b[15];
      stage.divisor = mag_a;
      stage.rem = 16'h0000;
      stage.dvd = {mag_b, 16'h0000};
      stage.rem_mid = 16'h0000;

      case (req.command)
         salu_pkg::CMD_SET: stage.res = req.operand_a;
         salu_pkg::CMD_ADD: begin
            stage.res = sum_ab[15:0];
            stage.exo = {15'h0000, sum_ab[16]};
         end
         salu_pkg::CMD_SUB: begin
            stage.res = req.operand_b - req.operand_a;
            stage.exo = (req.operand_a > req.operand_b) ? salu_pkg::ALL_ONES : 16'h0000;
         end
         salu_pkg::CMD_MUL, salu_pkg::CMD_MLI: begin
            stage.res = prod[15:0];
            stage.exo = prod[31:16];
         end
         salu_pkg::CMD_AND: stage.res = req.operand_b & req.operand_a;
         salu_pkg::CMD_BOR: stage.res = req.operand_b | req.operand_a;
         salu_pkg::CMD_XOR: stage.res = req.operand_b ^ req.operand_a;
         salu_pkg::CMD_SHR: begin
            stage.res = big_shift ? 16'h0000 : shr_v[31:16];
            stage.exo = big_shift ? 16'h0000 : shr_v[15:0];
         end
         salu_pkg::CMD_ASR: begin
            stage.res = asr_v[31:16];
            stage.exo = asr_v[15:0];
         end
         salu_pkg::CMD_SHL: begin
            stage.res = big_shift ? 16'h0000 : shl_v[15:0];
            stage.exo = big_shift ? 16'h0000 : shl_v[31:16];
         end
         salu_pkg::CMD_ADX: begin
            stage.res = sum_adx[15:0];
            stage.exo = (|sum_adx[17:16]) ? 16'h0001 : 16'h0000;
         end
         salu_pkg::CMD_SBX: begin
            stage.res = req.operand_b - req.operand_a + req.ex_in;
            stage.exo = (sum_aex < {1'b0, req.operand_b}) ? salu_pkg::ALL_ONES : 16'h0000;
         end
         default: ;
      endcase
   end

endmodule

// ===== hdl/salu_cell.sv =====
// one restoring division step with its pipeline register
module salu_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                snap,
   input  logic                in_valid,
   input  salu_pkg::stage_type in_stage,
   output logic                out_valid,
   output salu_pkg::stage_type out_stage
);

   logic                valid_ff;
   salu_pkg::stage_type stage_ff;
   salu_pkg::stage_type stage_in;
   logic [16:0]         shifted;
   logic [16:0]         diff;
   logic                take;

   always_comb begin
      shifted = {in_stage.rem, in_stage.dvd[31]};
      diff = shifted - {1'b0, in_stage.divisor};
      take = (shifted >= {1'b0, in_stage.divisor});
      stage_in = in_stage;
      stage_in.rem = take ? diff[15:0] : shifted[15:0];
      stage_in.dvd = {in_stage.dvd[30:0], take};
      if (snap) begin
         stage_in.rem_mid = stage_in.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== hdl/salu_post.sv =====
// back end: picks divide and modulo results and applies signs
module salu_post (
   input  salu_pkg::stage_type stage,
   output salu_pkg::rsp_type   rsp
);

   logic [31:0] q_neg;
   logic [15:0] r_neg;

   always_comb begin
      q_neg = -stage.dvd;
      r_neg = -stage.rem_mid;
      rsp.result = stage.res;
      rsp.ex_out = stage.exo;
      case (stage.command)
         salu_pkg::CMD_DIV: begin
            rsp.result = stage.dz ? 16'h0000 : stage.dvd[31:16];
            rsp.ex_out = stage.dz ? 16'h0000 : stage.dvd[15:0];
         end
         salu_pkg::CMD_DVI: begin
            if (stage.dz) begin
               rsp.result = 16'h0000;
               rsp.ex_out = 16'h0000;
            end else if (stage.neg_q) begin
               rsp.result = 16'(-stage.dvd[31:16]);
               rsp.ex_out = q_neg[15:0];
            end else begin
               rsp.result = stage.dvd[31:16];
               rsp.ex_out = stage.dvd[15:0];
            end
         end
         salu_pkg::CMD_MOD: rsp.result = stage.dz ? 16'h0000 : stage.rem_mid;
         salu_pkg::CMD_MDI: begin
            rsp.result = stage.dz ? 16'h0000 : (stage.neg_r ? r_neg : stage.rem_mid);
         end
         default: ;
      endcase
   end

endmodule

// ===== hdl/sixteen_bit_alu_with_ex.sv =====
// top level: sixteen-bit alu with ex word, divider as a chain of step cells
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  req_data (command, operand_b, operand_a, ex_in)
//   rsp      out  rsp_valid/rsp_ready  rsp_data (result, ex_out)
//
// one item enters per cycle unless the output stalls; rsp_valid follows the accepting
// edge through the 32 division step cell registers and the output register, the
// front stage is combinational and shares the accepting edge with the first cell.
// synchronous reset clears all valid bits; payload registers are not reset.
// a stalled output freezes the whole chain, req_ready follows it.
module sixteen_bit_alu_with_ex (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  salu_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output salu_pkg::rsp_type  rsp_data
);

   logic                adv;
   logic                valid_chain [salu_pkg::DIV_STEPS+1];
   salu_pkg::stage_type stage_chain [salu_pkg::DIV_STEPS+1];
   salu_pkg::rsp_type   rsp_in;
   salu_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff;

   assign adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign valid_chain[0] = req_valid;

   salu_prep u_prep (
      .req   (req_data),
      .stage (stage_chain[0])
   );

   for (genvar i = 0; i < salu_pkg::DIV_STEPS; i++) begin : g_cell
      salu_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .snap      (i == salu_pkg::MID_STEP - 1),
         .in_valid  (valid_chain[i]),
         .in_stage  (stage_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_stage (stage_chain[i+1])
      );
   end

   salu_post u_post (
      .stage (stage_chain[salu_pkg::DIV_STEPS]),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= valid_chain[salu_pkg::DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
